[sv/ifs_pkg.sv]
// ---------------------------------------------------------------------------
// ifs_pkg
// Shared types and constants for the image format sniffer.
// ---------------------------------------------------------------------------
package ifs_pkg;

  // Header bytes that the format checks look at.
  localparam int CHECK_BYTES = 22;

  // Number of detectable format codes (1 .. NUM_FORMATS).
  localparam int NUM_FORMATS = 20;

  // Depth of the queues between and behind the stages.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [4:0] {
    FMT_UNKNOWN  = 5'd0,
    FMT_BMP      = 5'd1,
    FMT_QOI      = 5'd2,
    FMT_FARBFELD = 5'd3,
    FMT_GIF      = 5'd4,
    FMT_PSD      = 5'd5,
    FMT_TIFF     = 5'd6,
    FMT_DDS      = 5'd7,
    FMT_RAS      = 5'd8,
    FMT_SGI      = 5'd9,
    FMT_PNG      = 5'd10,
    FMT_JPEG     = 5'd11,
    FMT_IFF      = 5'd12,
    FMT_WEBP     = 5'd13,
    FMT_EXR      = 5'd14,
    FMT_XBM      = 5'd15,
    FMT_ICO      = 5'd16,
    FMT_CUR      = 5'd17,
    FMT_PCX      = 5'd18,
    FMT_PNM      = 5'd19,
    FMT_TGA      = 5'd20
  } format_t;

  // One flag per format code; bit k-1 means code k matched.
  typedef logic [NUM_FORMATS-1:0] hits_t;

endpackage

[sv/ifs_queue.sv]
// ---------------------------------------------------------------------------
// ifs_queue
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module ifs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] data_in,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] data_out,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= data_in;
    end
  end

endmodule

[sv/ifs_front.sv]
// ---------------------------------------------------------------------------
// ifs_front
// Byte intake: header capture, byte count, and parallel magic-number checks
// on the final byte of each file.
// ---------------------------------------------------------------------------
module ifs_front
  import ifs_pkg::*;
#(
  parameter int HEADER_BYTES = 22,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  output logic       hits_push,
  output hits_t      hits
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [7:0]             hdr [HEADER_BYTES];
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] size;
  logic [7:0]             h [CHECK_BYTES];
  logic [15:0]            entries;
  logic [12:0]            ico_need;
  logic                   ico_base;

  // Size including the current byte, saturating.
  assign size = (count == COUNT_MAX) ? count : count + 1'b1;

  always_comb begin
    if (last_byte) begin
      count_next = '0;
    end else begin
      count_next = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (accept && count == COUNT_WIDTH'(i)) begin
        hdr[i] <= byte_value;
      end
    end
  end

  // Header view with the byte in flight merged in.
  always_comb begin
    for (int i = 0; i < CHECK_BYTES; i++) begin
      h[i] = (count == COUNT_WIDTH'(i)) ? byte_value : hdr[i];
    end
  end

  assign entries  = {h[5], h[4]};
  assign ico_need = {entries[8:0], 4'b0000} + 13'd6;
  assign ico_base = (size >= COUNT_WIDTH'(22)) && h[0] == 8'h00 && h[1] == 8'h00 &&
                    (h[2] == 8'h01 || h[2] == 8'h02) && h[3] == 8'h00 &&
                    entries != 16'd0 && entries <= 16'd256 &&
                    size >= COUNT_WIDTH'(ico_need);

  always_comb begin
    hits = '0;
    hits[FMT_BMP - 1] = (size >= COUNT_WIDTH'(2)) && h[0] == "B" && h[1] == "M";
    hits[FMT_QOI - 1] = (size >= COUNT_WIDTH'(14)) &&
                        {h[0], h[1], h[2], h[3]} == "qoif";
    hits[FMT_FARBFELD - 1] = (size >= COUNT_WIDTH'(16)) &&
                             {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]} ==
                             "farbfeld";
    hits[FMT_GIF - 1] = (size >= COUNT_WIDTH'(6)) &&
                        {h[0], h[1], h[2], h[3]} == "GIF8" &&
                        (h[4] == "7" || h[4] == "9") && h[5] == "a";
    hits[FMT_PSD - 1] = (size >= COUNT_WIDTH'(4)) &&
                        {h[0], h[1], h[2], h[3]} == "8BPS";
    hits[FMT_TIFF - 1] = (size >= COUNT_WIDTH'(4)) &&
                         (({h[0], h[1]} == "II" && h[2] == 8'd42 && h[3] == 8'd0) ||
                          ({h[0], h[1]} == "MM" && h[2] == 8'd0 && h[3] == 8'd42));
    hits[FMT_DDS - 1] = (size >= COUNT_WIDTH'(4)) &&
                        {h[0], h[1], h[2], h[3]} == "DDS ";
    hits[FMT_RAS - 1] = (size >= COUNT_WIDTH'(4)) &&
                        {h[0], h[1], h[2], h[3]} == 32'h59a6_6a95;
    hits[FMT_SGI - 1] = (size >= COUNT_WIDTH'(2)) && h[0] == 8'h01 && h[1] == 8'hda;
    hits[FMT_PNG - 1] = (size >= COUNT_WIDTH'(8)) && h[0] == 8'd137 &&
                        {h[1], h[2], h[3]} == "PNG";
    hits[FMT_JPEG - 1] = (size >= COUNT_WIDTH'(2)) && h[0] == 8'hff && h[1] == 8'hd8;
    hits[FMT_IFF - 1] = (size >= COUNT_WIDTH'(12)) &&
                        {h[0], h[1], h[2], h[3]} == "FORM" &&
                        ({h[8], h[9], h[10], h[11]} == "ILBM" ||
                         {h[8], h[9], h[10], h[11]} == "PBM ");
    hits[FMT_WEBP - 1] = (size >= COUNT_WIDTH'(12)) &&
                         {h[0], h[1], h[2], h[3]} == "RIFF" &&
                         {h[8], h[9], h[10], h[11]} == "WEBP";
    hits[FMT_EXR - 1] = (size >= COUNT_WIDTH'(4)) &&
                        {h[0], h[1], h[2], h[3]} == 32'h762f_3101;
    hits[FMT_XBM - 1] = (size >= COUNT_WIDTH'(9)) &&
                        {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]} ==
                        "#define ";
    hits[FMT_ICO - 1] = ico_base && h[2] == 8'h01;
    hits[FMT_CUR - 1] = ico_base && h[2] == 8'h02;
    hits[FMT_PCX - 1] = (size >= COUNT_WIDTH'(4)) && h[0] == 8'h0a && h[1] <= 8'd5 &&
                        h[2] == 8'd1 && (h[3] inside {8'd1, 8'd2, 8'd4, 8'd8});
    hits[FMT_PNM - 1] = (size >= COUNT_WIDTH'(2)) && h[0] == "P" &&
                        h[1] >= "1" && h[1] <= "7";
    hits[FMT_TGA - 1] = (size >= COUNT_WIDTH'(18)) && (h[1] inside {8'd0, 8'd1}) &&
                        (h[2] inside {8'd1, 8'd2, 8'd3, 8'd9, 8'd10, 8'd11}) &&
                        (h[16] inside {8'd8, 8'd15, 8'd16, 8'd24, 8'd32});
  end

  assign hits_push = accept && last_byte;

endmodule

[sv/ifs_back.sv]
// ---------------------------------------------------------------------------
// ifs_back
// Picks the first matching check and queues the format code for the reader.
// ---------------------------------------------------------------------------
module ifs_back
  import ifs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       hits_empty,
  input  hits_t      hits,
  output logic       hits_pop,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] format_code
);

  format_t code;
  logic    out_full;

  // Lowest code wins.
  always_comb begin
    code = FMT_UNKNOWN;
    for (int i = NUM_FORMATS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        code = format_t'(5'(i + 1));
      end
    end
  end

  assign hits_pop = !hits_empty && !out_full;

  ifs_queue #(
    .WIDTH (5),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (hits_pop),
    .data_in  (code),
    .full     (out_full),
    .pop      (pop),
    .data_out (format_code),
    .empty    (empty)
  );

endmodule

[sv/image_format_sniffer.sv]
// ---------------------------------------------------------------------------
// image_format_sniffer
// Identifies an image file format from the magic number at its start.
// ---------------------------------------------------------------------------
// Push one file byte per request, with last_byte set on the final byte; one
// format code (0 unknown, 1..20 per format) comes out per file. The block
// takes a byte every cycle while full is low: the header checks run in
// parallel in the same cycle as the final byte, the result crosses a
// two-entry queue to the priority picker, and a two-entry output queue
// holds codes for the reader. full rises only when four classified files
// are waiting (two in the output queue, two behind it) because the reader
// has stopped popping. A final byte's result is registered in the middle
// queue and then in the output queue. No clearing pass follows reset.
module image_format_sniffer
  import ifs_pkg::*;
#(
  parameter int HEADER_BYTES = 22,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] format_code
);

  logic  accept;
  logic  hits_push;
  hits_t hits_in;
  hits_t hits_out;
  logic  hits_empty;
  logic  hits_pop;

  assign accept = push && !full;

  ifs_front #(
    .HEADER_BYTES (HEADER_BYTES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .hits_push  (hits_push),
    .hits       (hits_in)
  );

  ifs_queue #(
    .WIDTH (NUM_FORMATS),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (hits_push),
    .data_in  (hits_in),
    .full     (full),
    .pop      (hits_pop),
    .data_out (hits_out),
    .empty    (hits_empty)
  );

  ifs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .hits_empty  (hits_empty),
    .hits        (hits_out),
    .hits_pop    (hits_pop),
    .empty       (empty),
    .pop         (pop),
    .format_code (format_code)
  );

`ifndef NO_ASSERTIONS
  a_final_byte_queued: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> !hits_empty)
    else $error("final byte did not queue a classification");

  a_pick_reaches_output: assert property (@(posedge clk) disable iff (rst)
    hits_pop |=> !empty)
    else $error("picked format code did not reach the output queue");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (format_code <= 5'(NUM_FORMATS)))
    else $error("format code out of range");
`endif

endmodule

[bench/format_checker.sv]
// ---------------------------------------------------------------------------
// format_checker
// Predicts the format code of every file pushed into the sniffer and compares
// each popped code, in order, against the prediction.
// ---------------------------------------------------------------------------
module format_checker
  import ifs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [4:0] format_code,
  output int         mismatches,
  output int         waiting
);

  localparam int HDR_LEN = CHECK_BYTES;

  logic [7:0]  hdr [HDR_LEN];
  logic [15:0] seen;
  format_t     codes_due [$];

  function automatic bit hdr_has(input int off, input string s);
    for (int i = 0; i < s.len(); i++)
      if (hdr[off + i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  // First match wins; every header read sits behind its size guard.
  function automatic format_t sniff_format(input int size);
    int n;
    n = {hdr[5], hdr[4]};
    if (size >= 2 && hdr_has(0, "BM")) return FMT_BMP;
    if (size >= 14 && hdr_has(0, "qoif")) return FMT_QOI;
    if (size >= 16 && hdr_has(0, "farbfeld")) return FMT_FARBFELD;
    if (size >= 6 && (hdr_has(0, "GIF87a") || hdr_has(0, "GIF89a"))) return FMT_GIF;
    if (size >= 4 && hdr_has(0, "8BPS")) return FMT_PSD;
    if (size >= 4 && ((hdr_has(0, "II") && hdr[2] == 8'd42 && hdr[3] == 8'd0) ||
                      (hdr_has(0, "MM") && hdr[2] == 8'd0 && hdr[3] == 8'd42)))
      return FMT_TIFF;
    if (size >= 4 && hdr_has(0, "DDS ")) return FMT_DDS;
    if (size >= 4 && hdr[0] == 8'h59 && hdr[1] == 8'ha6 && hdr[2] == 8'h6a &&
        hdr[3] == 8'h95)
      return FMT_RAS;
    if (size >= 2 && hdr[0] == 8'h01 && hdr[1] == 8'hda) return FMT_SGI;
    if (size >= 8 && hdr[0] == 8'd137 && hdr_has(1, "PNG")) return FMT_PNG;
    if (size >= 2 && hdr[0] == 8'hff && hdr[1] == 8'hd8) return FMT_JPEG;
    if (size >= 12 && hdr_has(0, "FORM") && (hdr_has(8, "ILBM") || hdr_has(8, "PBM ")))
      return FMT_IFF;
    if (size >= 12 && hdr_has(0, "RIFF") && hdr_has(8, "WEBP")) return FMT_WEBP;
    if (size >= 4 && hdr[0] == 8'h76 && hdr[1] == 8'h2f && hdr[2] == 8'h31 &&
        hdr[3] == 8'h01)
      return FMT_EXR;
    if (size >= 9 && hdr_has(0, "#define ")) return FMT_XBM;
    // icon directory: entry count must fit the file
    if (size >= 22 && hdr[0] == 8'd0 && hdr[1] == 8'd0 && (hdr[2] == 8'd1 || hdr[2] == 8'd2) &&
        hdr[3] == 8'd0 && n >= 1 && n <= 256 && size >= 6 + 16 * n)
      return (hdr[2] == 8'd1) ? FMT_ICO : FMT_CUR;
    if (size >= 4 && hdr[0] == 8'h0a && hdr[1] <= 8'd5 && hdr[2] == 8'd1 &&
        (hdr[3] == 8'd1 || hdr[3] == 8'd2 || hdr[3] == 8'd4 || hdr[3] == 8'd8))
      return FMT_PCX;
    if (size >= 2 && hdr[0] == "P" && hdr[1] >= "1" && hdr[1] <= "7") return FMT_PNM;
    if (size >= 18 && (hdr[1] == 8'd0 || hdr[1] == 8'd1) &&
        (hdr[2] == 8'd1 || hdr[2] == 8'd2 || hdr[2] == 8'd3 || hdr[2] == 8'd9 ||
         hdr[2] == 8'd10 || hdr[2] == 8'd11) &&
        (hdr[16] == 8'd8 || hdr[16] == 8'd15 || hdr[16] == 8'd16 || hdr[16] == 8'd24 ||
         hdr[16] == 8'd32))
      return FMT_TGA;
    return FMT_UNKNOWN;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic fin);
    if (seen < HDR_LEN) hdr[seen] = b;
    if (seen != 16'hffff) seen = seen + 16'd1;
    if (fin) begin
      codes_due.push_back(sniff_format(int'(seen)));
      seen = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t sniffer mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    format_t want;
    if (rst) begin
      seen = '0;
      codes_due.delete();
      for (int i = 0; i < HDR_LEN; i++) hdr[i] = '0;
    end else begin
      if (pop && !empty) begin
        if (codes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected code %0d", format_code));
        end else begin
          want = codes_due.pop_front();
          if (format_code !== want)
            report_mismatch($sformatf("code %0d, expected %0d", format_code, want));
        end
      end
      if (push && !full) take_byte(byte_value, last_byte);
    end
    waiting = codes_due.size();
  end

endmodule

[bench/image_format_sniffer_test.sv]
// ---------------------------------------------------------------------------
// image_format_sniffer_test
// Streams short files with valid, truncated and damaged magic numbers, plus
// noise, through the sniffer under varying sender and reader stalls.
// ---------------------------------------------------------------------------
module image_format_sniffer_test;
  import ifs_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RX_HOLD     = 300;
  localparam int PHASE_BYTES = 390;
  localparam int MAX_FILE    = 128;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       push       = 1'b0;
  logic [7:0] byte_value = '0;
  logic       last_byte  = 1'b0;
  logic       pop        = 1'b0;
  logic       full;
  logic       empty;
  logic [4:0] format_code;

  int         mismatches;
  int         waiting;
  int         phase      = 0;
  int         tx_pct     = 29;
  int         bytes_sent = 0;
  int         quiet      = 0;
  int         hold_left  = 0;
  logic       hold_rx    = 1'b0;
  logic       hold_taken = 1'b0;
  logic [7:0] file_q [$];

  image_format_sniffer dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .byte_value  (byte_value),
    .last_byte   (last_byte),
    .empty       (empty),
    .pop         (pop),
    .format_code (format_code)
  );

  format_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .byte_value  (byte_value),
    .last_byte   (last_byte),
    .empty       (empty),
    .pop         (pop),
    .format_code (format_code),
    .mismatches  (mismatches),
    .waiting     (waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reader: random pops, one long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_rx && !hold_taken) begin
      pop <= 1'b0;
      hold_left <= RX_HOLD;
      hold_taken <= 1'b1;
    end else begin
      pop <= ($urandom_range(0, 99) >= ((phase == 0) ? 84 : (phase == 1) ? 29 : 0));
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[image_format_sniffer] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < tx_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    byte_value <= b;
    last_byte <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    bytes_sent += file_q.size();
  endtask

  // Builds one file: a magic number with random body, near its size guard,
  // sometimes with one header bit flipped; or plain noise.
  task automatic make_file(input bit big);
    int pick;
    int need;
    int len;
    int n;
    int idx;
    logic [7:0] tga_kinds [6] = '{8'd1, 8'd2, 8'd3, 8'd9, 8'd10, 8'd11};
    logic [7:0] tga_depths [5] = '{8'd8, 8'd15, 8'd16, 8'd24, 8'd32};
    logic [7:0] pcx_depths [4] = '{8'd1, 8'd2, 8'd4, 8'd8};
    file_q.delete();
    pick = big ? int'(FMT_ICO) : $urandom_range(0, 21);
    need = 1;
    case (pick)
      FMT_BMP: begin add_str("BM"); need = 2; end
      FMT_QOI: begin add_str("qoif"); need = 14; end
      FMT_FARBFELD: begin add_str("farbfeld"); need = 16; end
      FMT_GIF: begin
        if ($urandom_range(0, 1)) add_str("GIF87a");
        else add_str("GIF89a");
        need = 6;
      end
      FMT_PSD: begin add_str("8BPS"); need = 4; end
      FMT_TIFF: begin
        if ($urandom_range(0, 1)) file_q = {8'h49, 8'h49, 8'd42, 8'd0};
        else file_q = {8'h4d, 8'h4d, 8'd0, 8'd42};
        need = 4;
      end
      FMT_DDS: begin add_str("DDS "); need = 4; end
      FMT_RAS: begin file_q = {8'h59, 8'ha6, 8'h6a, 8'h95}; need = 4; end
      FMT_SGI: begin file_q = {8'h01, 8'hda}; need = 2; end
      FMT_PNG: begin file_q = {8'd137}; add_str("PNG"); need = 8; end
      FMT_JPEG: begin file_q = {8'hff, 8'hd8}; need = 2; end
      FMT_IFF: begin
        add_str("FORM");
        repeat (4) file_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) add_str("ILBM");
        else add_str("PBM ");
        need = 12;
      end
      FMT_WEBP: begin
        add_str("RIFF");
        repeat (4) file_q.push_back(8'($urandom_range(0, 255)));
        add_str("WEBP");
        need = 12;
      end
      FMT_EXR: begin file_q = {8'h76, 8'h2f, 8'h31, 8'h01}; need = 4; end
      FMT_XBM: begin add_str("#define "); need = 9; end
      FMT_ICO, FMT_CUR: begin
        case ($urandom_range(0, 15))
          0: n = 0;
          1: n = 256;
          2: n = 257;
          3: n = $urandom_range(0, 65535);
          default: n = $urandom_range(1, 3);
        endcase
        if (big) n = 16;
        file_q = {8'h00, 8'h00, (pick == FMT_ICO) ? 8'h01 : 8'h02, 8'h00, n[7:0], n[15:8]};
        need = (n >= 1 && n <= 256 && 6 + 16 * n > 22) ? 6 + 16 * n : 22;
      end
      FMT_PCX: begin
        file_q.push_back(8'h0a);
        file_q.push_back(8'($urandom_range(0, 6)));
        file_q.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : 8'd1);
        file_q.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
                         pcx_depths[$urandom_range(0, 3)]);
        need = 4;
      end
      FMT_PNM: begin
        file_q.push_back("P");
        file_q.push_back(8'($urandom_range(8'h30, 8'h38)));
        need = 2;
      end
      FMT_TGA: begin
        file_q.push_back(8'($urandom_range(0, 255)));
        file_q.push_back(8'($urandom_range(0, 2)));
        file_q.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
                         tga_kinds[$urandom_range(0, 5)]);
        repeat (13) file_q.push_back(8'($urandom_range(0, 255)));
        file_q.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
                         tga_depths[$urandom_range(0, 4)]);
        need = 18;
      end
      default: need = $urandom_range(1, 40);
    endcase
    len = need - 1 + $urandom_range(0, 6);
    if (big) len = need;
    else if (len > MAX_FILE) len = MAX_FILE;
    if (len < 1) len = 1;
    while (file_q.size() < len) file_q.push_back(8'($urandom_range(0, 255)));
    while (file_q.size() > len) void'(file_q.pop_back());
    if (!big && $urandom_range(0, 5) == 0) begin
      idx = $urandom_range(0, ((len < 8) ? len : 8) - 1);
      file_q[idx] = file_q[idx] ^ 8'(1 << $urandom_range(0, 7));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one-byte files, two-byte magics, size guards just missed
    file_q = {8'h00}; send_file();
    file_q = {8'hff}; send_file();
    file_q = {8'hff, 8'hd8}; send_file();
    file_q = {8'h42, 8'h4d}; send_file();
    file_q = {8'h01, 8'hda}; send_file();
    file_q = {8'h50, 8'h37}; send_file();
    file_q = {8'h59, 8'ha6, 8'h6a, 8'h95}; send_file();
    file_q = {8'h0a, 8'h05, 8'h01, 8'h08}; send_file();
    file_q.delete(); add_str("GIF89"); send_file();

    for (int p = 0; p < 3; p++) begin
      phase <= p;
      tx_pct = (p == 0) ? 29 : (p == 1) ? 84 : 0;
      if (p == 2) begin
        // icon directory at its exact size, then a long reader stall
        // while files keep streaming in
        make_file(1'b1);
        send_file();
        hold_rx <= 1'b1;
      end
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        make_file(1'b0);
        send_file();
      end
      push <= 1'b0;
      wait (waiting == 0);
      @(negedge clk);
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && waiting == 0) $display("[image_format_sniffer] OK");
    else $display("[image_format_sniffer] ERROR");
    $finish;
  end

endmodule
